@@ rtl/apr_pkg.sv @@
// Shared types and constants for the aging page replacement block.
// No dependencies; used by the top level by scoped names.
package apr_pkg;

    localparam int FUNC_W  = 2;
    localparam int FRAME_W = 7;
    localparam int CFG_W   = 8;

    localparam logic [FUNC_W-1:0] FUNC_REFERENCE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MAP       = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SELECT    = 2'd2;

    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 8'd128;

    typedef logic [FUNC_W-1:0]  func_t;
    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [CFG_W-1:0]   cfg_t;

endpackage

@@ rtl/apr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module apr_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/aging_page_replacement.sv @@
// Top level of the aging page replacement victim selector.
// Depends on apr_pkg (codes, widths) and apr_ram (age and referenced-bit store).
//
// Usage:
//   A request is taken on a rising edge with start high and busy low; func and
//   frame_index travel with it. A reference request sets the frame's referenced
//   bit; it reads the word on acceptance and writes it back while busy is high.
//   A map request clears the frame's age and marks it referenced in the cycle
//   it is accepted, with no busy time. A select request walks every frame in
//   use starting at the scan hand, ages each one and picks the youngest; busy
//   stays high for the whole scan, which covers n frames, n being the clamped
//   frames_in_use, with one RAM read and one write-back per frame.
//   In the first cycle that busy is low again, done pulses for exactly one
//   cycle with victim_frame; the receiver has no way to stall it and must take
//   it then. Reference and map requests, and func 3, give no result.
//   frames_in_use is written through frames_in_use_we / frames_in_use_wdata;
//   the user must write it only while the block is idle, which the block
//   does not enforce. After reset a clearing pass zeroes every stored word,
//   holding busy high; configuration writes are still taken during that pass.
module aging_page_replacement #(
    parameter int FRAME_COUNT = 128,
    parameter int AGE_WIDTH   = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  apr_pkg::func_t       func,
    input  apr_pkg::frame_t      frame_index,
    input  logic                 frames_in_use_we,
    input  apr_pkg::cfg_t        frames_in_use_wdata,
    output logic                 done,
    output apr_pkg::frame_t      victim_frame
);

    localparam int IDX_W  = $clog2(FRAME_COUNT);
    localparam int CNT_W  = $clog2(FRAME_COUNT + 1);
    localparam int CMP_W  = (CNT_W > apr_pkg::CFG_W) ? CNT_W : apr_pkg::CFG_W;
    localparam int WORD_W = AGE_WIDTH + 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_REF_WR = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     clr_idx_reg, clr_idx_next;
    apr_pkg::cfg_t        frames_in_use_reg;
    logic [IDX_W-1:0]     hand_reg, hand_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic                 p_vld_reg, p_vld_next;
    logic                 first_reg, first_next;
    logic                 done_reg, done_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     p_idx_reg, p_idx_next;
    logic [IDX_W-1:0]     ref_addr_reg, ref_addr_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [AGE_WIDTH-1:0] best_age_reg, best_age_next;
    apr_pkg::frame_t      victim_reg, victim_next;

    logic [CMP_W-1:0]     fiu_w, n_now_w, fidx_w, hand_w, best_w;
    logic [CNT_W-1:0]     n_now, rd_inc, best_inc;
    logic [IDX_W-1:0]     frame_addr, scan_first;
    logic                 in_range, accept;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;
    logic                 old_ref;
    logic [AGE_WIDTH-1:0] old_age, new_age;

    apr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (FRAME_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Clamp the frame count to 1..FRAME_COUNT.
    always_comb
    begin
        fiu_w = CMP_W'(frames_in_use_reg);
        if (fiu_w == '0)
        begin
            n_now_w = CMP_W'(1);
        end
        else if (fiu_w > CMP_W'(FRAME_COUNT))
        begin
            n_now_w = CMP_W'(FRAME_COUNT);
        end
        else
        begin
            n_now_w = fiu_w;
        end
    end

    assign n_now      = n_now_w[CNT_W-1:0];
    assign fidx_w     = CMP_W'(frame_index);
    assign in_range   = (fidx_w < n_now_w);
    assign frame_addr = fidx_w[IDX_W-1:0];
    assign hand_w     = CMP_W'(hand_reg);
    // A hand left beyond a lowered frame count restarts the scan at frame zero.
    assign scan_first = (hand_w < n_now_w) ? hand_reg : '0;
    assign accept     = start && (state_reg == ST_IDLE);

    // Each stored word holds the referenced bit above the age.
    assign old_ref  = ram_rdata[AGE_WIDTH];
    assign old_age  = ram_rdata[AGE_WIDTH-1:0];
    assign new_age  = {old_ref, old_age[AGE_WIDTH-1:1]};
    assign rd_inc   = CNT_W'(rd_idx_reg) + CNT_W'(1);
    assign best_inc = CNT_W'(best_idx_reg) + CNT_W'(1);
    assign best_w   = CMP_W'(best_idx_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_idx_reg;
        ram_wdata = '0;
        ram_raddr = (state_reg == ST_SCAN) ? rd_idx_reg : frame_addr;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
            end
            ST_IDLE:
            begin
                if (accept && (func == apr_pkg::FUNC_MAP) && in_range)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = frame_addr;
                    ram_wdata = {1'b1, {AGE_WIDTH{1'b0}}};
                end
            end
            ST_REF_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ref_addr_reg;
                ram_wdata = {1'b1, old_age};
            end
            ST_SCAN:
            begin
                if (p_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = p_idx_reg;
                    ram_wdata = {1'b0, new_age};
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        hand_next     = hand_reg;
        n_next        = n_reg;
        left_next     = left_reg;
        p_vld_next    = p_vld_reg;
        first_next    = first_reg;
        done_next     = 1'b0;
        rd_idx_next   = rd_idx_reg;
        p_idx_next    = p_idx_reg;
        ref_addr_next = ref_addr_reg;
        best_idx_next = best_idx_reg;
        best_age_next = best_age_reg;
        victim_next   = victim_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(FRAME_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((func == apr_pkg::FUNC_REFERENCE) && in_range)
                    begin
                        ref_addr_next = frame_addr;
                        state_next    = ST_REF_WR;
                    end
                    else if (func == apr_pkg::FUNC_SELECT)
                    begin
                        n_next      = n_now;
                        left_next   = n_now;
                        rd_idx_next = scan_first;
                        p_vld_next  = 1'b0;
                        first_next  = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_REF_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // Reads run one frame ahead of the age update and write-back.
                if (left_reg != '0)
                begin
                    p_vld_next  = 1'b1;
                    p_idx_next  = rd_idx_reg;
                    rd_idx_next = (rd_inc == n_reg) ? '0 : rd_idx_reg + IDX_W'(1);
                    left_next   = left_reg - CNT_W'(1);
                end
                else
                begin
                    p_vld_next = 1'b0;
                end
                if (p_vld_reg)
                begin
                    first_next = 1'b0;
                    // Strict compare keeps the earliest-scanned frame on a tie.
                    if (first_reg || (new_age < best_age_reg))
                    begin
                        best_idx_next = p_idx_reg;
                        best_age_next = new_age;
                    end
                    if (left_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                done_next   = 1'b1;
                victim_next = best_w[apr_pkg::FRAME_W-1:0];
                hand_next   = (best_inc == n_reg) ? '0 : best_idx_reg + IDX_W'(1);
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_idx_reg       <= '0;
            frames_in_use_reg <= apr_pkg::FRAMES_IN_USE_RESET;
            hand_reg          <= '0;
            n_reg             <= '0;
            left_reg          <= '0;
            p_vld_reg         <= 1'b0;
            first_reg         <= 1'b0;
            done_reg          <= 1'b0;
            rd_idx_reg        <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            if (frames_in_use_we)
            begin
                frames_in_use_reg <= frames_in_use_wdata;
            end
            hand_reg   <= hand_next;
            n_reg      <= n_next;
            left_reg   <= left_next;
            p_vld_reg  <= p_vld_next;
            first_reg  <= first_next;
            done_reg   <= done_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg    <= p_idx_next;
        ref_addr_reg <= ref_addr_next;
        best_idx_reg <= best_idx_next;
        best_age_reg <= best_age_next;
        victim_reg   <= victim_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign victim_frame = victim_reg;

    // A result only follows the finishing step of a scan.
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_FINISH))
        else $error("result strobe without a finished scan");

    // The chosen victim always lies inside the scanned range.
    a_victim_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (CNT_W'(best_idx_reg) < n_reg))
        else $error("victim outside the frames in use");

    // The write-back never lands on the frame being read in the same cycle while frames are left to read.
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) && p_vld_reg && (left_reg != '0))
            |-> (rd_idx_reg != p_idx_reg))
        else $error("scan read and write-back hit the same frame");

    // The scan always visits exactly n frames before finishing.
    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> ((left_reg == '0) && !p_vld_reg))
        else $error("scan finished with frames still pending");

endmodule
